>>> design/dbfs_pkg.sv
// Shared types and constants for the deep-binding frame stack.
`timescale 1ns / 1ps

package dbfs_pkg;

   // Fixed field widths of the request and response words, and the default stack depth
   localparam int SYMBOL_BITS       = 16;
   localparam int VALUE_BITS        = 32;
   localparam int FRAME_BITS        = 9;
   localparam int STACK_ENTRIES_DEF = 256;

   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_BIND   = 2'd2,
      KIND_LOOKUP = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_FRAME = 2'd2
   } status_type;

   typedef struct packed {
      kind_type               kind;
      logic [SYMBOL_BITS-1:0] symbol;
      logic [VALUE_BITS-1:0]  bind_value;
   } req_word_type;

   typedef struct packed {
      logic                   found;
      logic [VALUE_BITS-1:0]  found_value;
      status_type             status;
      logic [FRAME_BITS-1:0]  frame_depth;
   } rsp_word_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE      = 3'd0,
      S_EXEC      = 3'd1,
      S_POP_WAIT  = 3'd2,
      S_SCAN      = 3'd3,
      S_LOOK_DONE = 3'd4
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic do_push;
      logic do_bind;
      logic rd_mark;
      logic do_pop;
      logic pop_fail;
      logic lookup_miss;
      logic scan_start;
      logic scan_step;
      logic scan_end;
      logic lookup_done;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     pop_bad;
      logic     lookup_skip;
      logic     scan_hit;
      logic     scan_last;
      logic     out_free;
   } dp_status_type;

endpackage

>>> design/dbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/dbfs_ctrl.sv
// Controller state machine for the deep-binding frame stack.
`timescale 1ns / 1ps

module dbfs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dbfs_pkg::dp_status_type dp_status,
   output dbfs_pkg::ctrl_cmd_type  cmd
);

   dbfs_pkg::state_type state_ff;
   dbfs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbfs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbfs_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = dbfs_pkg::S_EXEC;
            end
         end
         dbfs_pkg::S_EXEC: begin
            unique case (dp_status.kind)
               dbfs_pkg::KIND_PUSH, dbfs_pkg::KIND_BIND: begin
                  if (dp_status.out_free) begin
                     state_in = dbfs_pkg::S_IDLE;
                  end
               end
               dbfs_pkg::KIND_POP: begin
                  if (!dp_status.pop_bad) begin
                     state_in = dbfs_pkg::S_POP_WAIT;
                  end else if (dp_status.out_free) begin
                     state_in = dbfs_pkg::S_IDLE;
                  end
               end
               dbfs_pkg::KIND_LOOKUP: begin
                  if (!dp_status.lookup_skip) begin
                     state_in = dbfs_pkg::S_SCAN;
                  end else if (dp_status.out_free) begin
                     state_in = dbfs_pkg::S_IDLE;
                  end
               end
               default: state_in = dbfs_pkg::S_IDLE;
            endcase
         end
         dbfs_pkg::S_POP_WAIT: begin
            if (dp_status.out_free) begin
               state_in = dbfs_pkg::S_IDLE;
            end
         end
         dbfs_pkg::S_SCAN: begin
            if (dp_status.scan_hit || dp_status.scan_last) begin
               state_in = dbfs_pkg::S_LOOK_DONE;
            end
         end
         dbfs_pkg::S_LOOK_DONE: begin
            if (dp_status.out_free) begin
               state_in = dbfs_pkg::S_IDLE;
            end
         end
         default: state_in = dbfs_pkg::S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dbfs_pkg::S_IDLE: begin
            // no word is taken while reset is held
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         dbfs_pkg::S_EXEC: begin
            unique case (dp_status.kind)
               dbfs_pkg::KIND_PUSH: cmd.do_push = dp_status.out_free;
               dbfs_pkg::KIND_BIND: cmd.do_bind = dp_status.out_free;
               dbfs_pkg::KIND_POP: begin
                  if (dp_status.pop_bad) begin
                     cmd.pop_fail = dp_status.out_free;
                  end else begin
                     cmd.rd_mark = 1'b1;
                  end
               end
               dbfs_pkg::KIND_LOOKUP: begin
                  if (dp_status.lookup_skip) begin
                     cmd.lookup_miss = dp_status.out_free;
                  end else begin
                     cmd.scan_start = 1'b1;
                  end
               end
               default: cmd = '0;
            endcase
         end
         dbfs_pkg::S_POP_WAIT: cmd.do_pop = dp_status.out_free;
         dbfs_pkg::S_SCAN: begin
            if (dp_status.scan_hit || dp_status.scan_last) begin
               cmd.scan_end = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         dbfs_pkg::S_LOOK_DONE: cmd.lookup_done = dp_status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> design/dbfs_dp.sv
// Datapath: stack memory, top/base/frame registers, scan pointer, response register.
`timescale 1ns / 1ps

module dbfs_dp #(
   parameter int STACK_ENTRIES = dbfs_pkg::STACK_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dbfs_pkg::req_word_type  req_word,
   input  dbfs_pkg::ctrl_cmd_type  cmd,
   output dbfs_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dbfs_pkg::rsp_word_type  rsp_word
);

   localparam int SYM_W   = dbfs_pkg::SYMBOL_BITS;
   localparam int VAL_W   = dbfs_pkg::VALUE_BITS;
   localparam int FRAME_W = dbfs_pkg::FRAME_BITS;
   localparam int ADDR_W  = $clog2(STACK_ENTRIES);
   localparam int PTR_W   = $clog2(STACK_ENTRIES + 1);
   localparam int WORD_W  = SYM_W + VAL_W;

   dbfs_pkg::req_word_type req_ff;
   dbfs_pkg::rsp_word_type rsp_ff;
   dbfs_pkg::rsp_word_type rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_load;
   logic [PTR_W-1:0]       top_ff, top_in;
   logic [PTR_W-1:0]       base_ff, base_in;
   logic [PTR_W-1:0]       frames_ff, frames_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic                   hit_ff, hit_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [WORD_W-1:0]      wr_data;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [WORD_W-1:0]      rd_word;
   logic [SYM_W-1:0]       rd_sym;
   logic [VAL_W-1:0]       rd_val;
   logic [PTR_W-1:0]       marker;
   logic [PTR_W-1:0]       top_dec;
   logic                   full;
   logic                   out_free;

   dbfs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_ENTRIES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_sym   = rd_word[WORD_W-1 -: SYM_W];
   assign rd_val   = rd_word[VAL_W-1:0];
   assign marker   = base_ff - PTR_W'(1);
   assign top_dec  = top_ff - PTR_W'(1);
   assign full     = (top_ff == PTR_W'(STACK_ENTRIES));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Status back to the controller
   always_comb begin
      dp_status.kind        = req_ff.kind;
      dp_status.pop_bad     = (frames_ff == '0) || (base_ff == '0) || (base_ff > top_ff);
      dp_status.lookup_skip = (req_ff.symbol == '0) || (top_ff == '0);
      dp_status.scan_hit    = (rd_sym == req_ff.symbol);
      dp_status.scan_last   = (ptr_ff == '0);
      dp_status.out_free    = out_free;
   end

   // Memory read address: frame marker, top of stack, or next entry down
   always_comb begin
      rd_en = cmd.rd_mark || cmd.scan_start || cmd.scan_step;
      if (cmd.rd_mark) begin
         rd_addr = marker[ADDR_W-1:0];
      end else if (cmd.scan_start) begin
         rd_addr = top_dec[ADDR_W-1:0];
      end else begin
         rd_addr = ptr_ff - ADDR_W'(1);
      end
   end

   // Stack pointer updates, memory writes and the response word
   always_comb begin
      top_in    = top_ff;
      base_in   = base_ff;
      frames_in = frames_ff;
      ptr_in    = ptr_ff;
      hit_in    = hit_ff;
      wr_en     = 1'b0;
      wr_addr   = top_ff[ADDR_W-1:0];
      wr_data   = {req_ff.symbol, req_ff.bind_value};
      rsp_load  = 1'b0;
      rsp_in    = rsp_ff;
      rsp_in.found       = 1'b0;
      rsp_in.found_value = '0;
      rsp_in.status      = dbfs_pkg::STATUS_OK;

      if (cmd.do_push) begin
         rsp_load = 1'b1;
         if (full) begin
            rsp_in.status = dbfs_pkg::STATUS_FULL;
         end else begin
            // marker entry: reserved symbol, saved base in the value field
            wr_en     = 1'b1;
            wr_data   = {{SYM_W{1'b0}}, VAL_W'(base_ff)};
            top_in    = top_ff + PTR_W'(1);
            base_in   = top_ff + PTR_W'(1);
            frames_in = frames_ff + PTR_W'(1);
         end
      end else if (cmd.do_bind) begin
         rsp_load = 1'b1;
         if (full) begin
            rsp_in.status = dbfs_pkg::STATUS_FULL;
         end else begin
            wr_en  = 1'b1;
            top_in = top_ff + PTR_W'(1);
         end
      end else if (cmd.do_pop) begin
         // cut back to the marker and restore the saved base
         rsp_load  = 1'b1;
         top_in    = marker;
         base_in   = (rd_val <= VAL_W'(marker)) ? rd_val[PTR_W-1:0] : marker;
         frames_in = frames_ff - PTR_W'(1);
      end else if (cmd.pop_fail) begin
         rsp_load      = 1'b1;
         rsp_in.status = dbfs_pkg::STATUS_NO_FRAME;
      end else if (cmd.lookup_miss) begin
         rsp_load = 1'b1;
      end else if (cmd.scan_start) begin
         ptr_in = top_dec[ADDR_W-1:0];
      end else if (cmd.scan_step) begin
         ptr_in = ptr_ff - ADDR_W'(1);
      end else if (cmd.scan_end) begin
         hit_in = dp_status.scan_hit;
      end else if (cmd.lookup_done) begin
         rsp_load           = 1'b1;
         rsp_in.found       = hit_ff;
         rsp_in.found_value = hit_ff ? rd_val : '0;
      end

      rsp_in.frame_depth = FRAME_W'(frames_in);
   end

   // Output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         base_ff      <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         base_ff      <= base_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      ptr_ff <= ptr_in;
      hit_ff <= hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= PTR_W'(STACK_ENTRIES))
      else $error("stack top beyond capacity");

   a_open_frame_base: assert property (@(posedge clock) disable iff (reset)
      frames_ff != '0 |-> (base_ff != '0) && (base_ff <= top_ff))
      else $error("open frame without a valid base");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("response loaded over an untaken word");

   a_scan_below_top: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_end |-> PTR_W'(ptr_ff) < top_ff)
      else $error("scan pointer at or above top");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |=> top_ff < $past(top_ff))
      else $error("pop did not shrink the stack");
`endif

endmodule

>>> design/dynamic_binding_frame_stack.sv
// Top level of the deep-binding frame stack: controller plus datapath.
`timescale 1ns / 1ps

// Control stack of a deep-binding interpreter environment. Each request word
// pushes a frame, pops a frame, binds a symbol or looks one up; every request
// gives exactly one response word with found flag, value, status and the number
// of open frames. The stack lives in one single-port-read RAM of STACK_ENTRIES
// entries, and a lookup reads it one entry per cycle from the top down until
// the newest match or the bottom entry. Push, bind and a failed pop are done
// in the execute state, a good pop adds one RAM read of the frame marker, a
// lookup of symbol 0 or on an empty stack is answered as a miss with no scan,
// and any other lookup scans the entries, then loads its response. One
// request is in work at a time; a finished response waits in an output
// register while the next request is taken, and work stalls only if a second
// response is ready before the first is taken.

module dynamic_binding_frame_stack #(
   parameter int STACK_ENTRIES = dbfs_pkg::STACK_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dbfs_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dbfs_pkg::rsp_word_type rsp_word
);

   dbfs_pkg::ctrl_cmd_type  cmd;
   dbfs_pkg::dp_status_type dp_status;

   dbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   dbfs_dp #(
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
